// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define DQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define DQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dqhr_pkg.sv =====
// types and constants of the half-rotate deque
package dqhr_pkg;

  localparam int KIND_W = 3;
  localparam int WORD_W = 32;

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_ROTATE     = 3'd4
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic take;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== rtl/dqhr_ctrl.sv =====
// controller state machine of the half-rotate deque
module dqhr_ctrl
  import dqhr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_tready,
  input  logic              out_tready,
  input  dp_sts_t           sts,
  output dp_cmd_t           cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   is_pop;
  logic   take;

  always_comb begin
    unique case (op_t'(in_kind)) inside
      OP_POP_FRONT, OP_POP_BACK: is_pop = 1'b1;
      default:                   is_pop = 1'b0;
    endcase
  end

  assign take = in_tvalid && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take && is_pop) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (!sts.out_busy || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd.take  = 1'b0;
    cmd.load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
      end
      S_HOLD: begin
        cmd.load = !sts.out_busy || out_tready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/dqhr_dp.sv =====
// datapath of the half-rotate deque: ring pointers, word memory, result register
module dqhr_dp
  import dqhr_pkg::*;
#(
  parameter int DEPTH = 1024
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [WORD_W-1:0] in_value,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [WORD_W-1:0] out_value,
  output logic              out_empty
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [WORD_W-1:0] mem [DEPTH];

  logic [IW-1:0]     front_r;
  logic [IW-1:0]     front_nxt;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [CW-1:0]     offset;
  logic [SW-1:0]     sum;
  logic [SW-1:0]     wrapped;
  logic [IW-1:0]     ring_pos;
  logic [IW-1:0]     front_dec;
  logic              full;
  logic              empty;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data_r;
  logic              pop_empty_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [WORD_W-1:0] out_value_r;
  logic              out_empty_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    unique case (op_t'(in_kind))
      OP_PUSH_BACK: offset = count_r;
      OP_POP_BACK:  offset = count_r - 1'b1;
      OP_POP_FRONT: offset = CW'(1);
      OP_ROTATE:    offset = count_r >> 1;
      default:      offset = '0;
    endcase
  end

  // one add and one compare give the ring position for every kind but the push to the front
  assign sum       = SW'(front_r) + SW'(offset);
  assign wrapped   = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
  assign ring_pos  = wrapped[IW-1:0];
  assign front_dec = (front_r == '0) ? IW'(DEPTH - 1) : (front_r - 1'b1);

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = ring_pos;
    rd_en     = 1'b0;
    rd_addr   = ring_pos;
    if (cmd.take) begin
      unique case (op_t'(in_kind))
        OP_PUSH_FRONT: begin
          if (!full) begin
            front_nxt = front_dec;
            count_nxt = count_r + 1'b1;
            wr_en     = 1'b1;
            wr_addr   = front_dec;
          end
        end
        OP_PUSH_BACK: begin
          if (!full) begin
            count_nxt = count_r + 1'b1;
            wr_en     = 1'b1;
          end
        end
        OP_POP_FRONT: begin
          rd_en   = 1'b1;
          rd_addr = front_r;
          if (!empty) begin
            front_nxt = ring_pos;
            count_nxt = count_r - 1'b1;
          end
        end
        OP_POP_BACK: begin
          rd_en = 1'b1;
          if (!empty) count_nxt = count_r - 1'b1;
        end
        OP_ROTATE: begin
          if (count_r > CW'(1)) front_nxt = ring_pos;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_value;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r   <= mem[rd_addr];
      pop_empty_r <= empty;
    end
  end

  // result register parts the memory read from the output side
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_value_r <= pop_empty_r ? '0 : rd_data_r;
      out_empty_r <= pop_empty_r;
    end
  end

  assign sts.out_busy = out_valid_r;
  assign out_tvalid   = out_valid_r;
  assign out_value    = out_value_r;
  assign out_empty    = out_empty_r;

endmodule

// ===== rtl/deque_with_half_rotate.sv =====
// Double-ended queue of signed 32-bit words in a ring buffer of DEPTH entries, with
// insert and remove at either end and a rotate that brings the second half ahead of
// the first. Items are taken one at a time. A remove holds off further items while
// the word is read from the single-port word memory into a registered read stage,
// then moved into the result register; it waits longer while a previous result is
// still held there. Inserts may go on while a result waits to be taken. A remove
// from an empty queue returns zero with the empty flag set; an insert into a full
// queue is dropped.
module deque_with_half_rotate
  import dqhr_pkg::*;
#(
  parameter int DEPTH = 1024
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // value_res[31:0]
  output logic [0:0]  out_tuser   // was_empty[0]
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  dqhr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dqhr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (in_tuser),
    .in_value   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_tdata),
    .out_empty  (out_tuser[0])
  );

endmodule

// ===== rtl/dqhr_checker.sv =====
// port-level checks of the half-rotate deque and their binding
`include "assert_macros.svh"

module dqhr_checker
  import dqhr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);

  logic in_take;
  logic pop_take;

  assign in_take  = in_tvalid && in_tready;
  assign pop_take = in_take && ((in_tuser == OP_POP_FRONT) || (in_tuser == OP_POP_BACK));

  `DQ_ASSERT(a_out_hold, clk, rst_n,
             out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser),
             "result changed while stalled")
  `DQ_ASSERT(a_empty_zero, clk, rst_n, out_tvalid && out_tuser[0] |-> out_tdata == 32'd0,
             "empty remove with nonzero word")
  `DQ_ASSERT(a_pop_busy, clk, rst_n, pop_take |=> !in_tready, "item taken during a remove")
  `DQ_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_tvalid, "result shown after reset")

endmodule

bind deque_with_half_rotate dqhr_checker u_dqhr_checker (.*);

// ===== bench/deque_with_half_rotate_tb.sv =====
// self-checking testbench for the half-rotate deque with a shadow queue model
module deque_with_half_rotate_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dqhr_pkg::*;

  localparam int DEPTH = 1024;
  localparam int MAX_IDLE = 12;
  localparam int SETTLE_CYCLES = 20;
  localparam int SEGMENT_ITEMS = 20;
  localparam int FULL_POPS = 16;
  localparam int RANDOM_ITEMS = 60;
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              empty;
  } pop_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata = '0;   // value[31:0]
  logic [2:0]        in_tuser = '0;   // kind[2:0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;       // value_res[31:0]
  logic [0:0]        out_tuser;       // was_empty[0]

  logic [WORD_W-1:0] shadow_words [DEPTH];
  int unsigned       shadow_front = 0;
  int unsigned       shadow_count = 0;
  pop_result_t       pending_pops [$];
  int                mismatches = 0;
  int                results_seen = 0;
  bit                quiet_in = 1'b0;
  bit                quiet_out = 1'b0;

  deque_with_half_rotate #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("deque_with_half_rotate: mismatch");
    $finish;
  end

  function automatic void predict_op(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] value);
    pop_result_t res;
    int unsigned slot;
    case (kind) inside
      OP_PUSH_FRONT: begin
        if (shadow_count < DEPTH) begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_words[shadow_front] = value;
          shadow_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_count < DEPTH) begin
          shadow_words[(shadow_front + shadow_count) % DEPTH] = value;
          shadow_count++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_count == 0) begin
          res.word = '0;
          res.empty = 1'b1;
        end else begin
          if (kind == OP_POP_FRONT) begin
            slot = shadow_front;
            shadow_front = (shadow_front + 1) % DEPTH;
          end else begin
            slot = (shadow_front + shadow_count - 1) % DEPTH;
          end
          shadow_count--;
          res.word = shadow_words[slot];
          res.empty = 1'b0;
        end
        pending_pops.push_back(res);
      end
      OP_ROTATE: begin
        if (shadow_count > 1)
          shadow_front = (shadow_front + shadow_count / 2) % DEPTH;
      end
      default: ;
    endcase
  endfunction

  // valid stays high after a handshake so back-to-back items need no toggle
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= value;
    do @(posedge clk); while (!in_tready);
    predict_op(kind, value);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_pops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = quiet_out ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    pop_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_pops.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d unexpected: word %h empty %b",
                   results_seen, out_tdata, out_tuser[0]);
      end else begin
        want = pending_pops.pop_front();
        if (out_tdata !== want.word || out_tuser[0] !== want.empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected word %h empty %b, got word %h empty %b",
                     results_seen, want.word, want.empty, out_tdata, out_tuser[0]);
        end
      end
    end
  end

  task automatic test_empty_queue();
    send_item(OP_POP_FRONT, 32'h1234_5678);
    send_item(OP_POP_BACK, 32'hffff_ffff);
    send_item(OP_ROTATE, '0);
    send_item(OP_PUSH_FRONT, 32'h5a5a_a5a5);
    send_item(OP_ROTATE, '0);
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
      send_item(KIND_W'(k), $urandom());
    send_item(OP_POP_BACK, '0);
    wait_drained();
  endtask

  task automatic test_value_extremes();
    send_item(OP_PUSH_FRONT, 32'h7fff_ffff);
    send_item(OP_PUSH_BACK, 32'h8000_0000);
    send_item(OP_PUSH_FRONT, 32'h0000_0000);
    send_item(OP_PUSH_BACK, 32'hffff_ffff);
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_BACK, '0);
    wait_drained();
  endtask

  // even count, then odd count, so both halves of the split are seen
  task automatic test_half_rotate();
    for (int i = 1; i <= 4; i++)
      send_item(OP_PUSH_BACK, 32'h1000 + i);
    send_item(OP_ROTATE, '0);
    send_item(OP_PUSH_FRONT, 32'h2000);
    send_item(OP_ROTATE, '0);
    repeat (5) send_item(OP_POP_FRONT, '0);
    wait_drained();
  endtask

  // the queue is left nearly full for the random mix that follows
  task automatic test_full_queue();
    quiet_in = 1'b1;
    while (shadow_count < DEPTH)
      send_item($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom());
    quiet_in = 1'b0;
    send_item(OP_PUSH_FRONT, $urandom());
    send_item(OP_PUSH_BACK, $urandom());
    send_item(OP_ROTATE, $urandom());
    repeat (FULL_POPS)
      send_item($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, $urandom());
    wait_drained();
  endtask

  // segments with their own push bias and idling so the fill level wanders
  task automatic test_random_ops(input int n_items);
    int done;
    int seg_left;
    int push_pct;
    int pick;
    logic [KIND_W-1:0] kind;
    done = 0;
    seg_left = 0;
    push_pct = 50;
    while (done < n_items) begin
      if (seg_left == 0) begin
        seg_left = SEGMENT_ITEMS;
        push_pct = $urandom_range(25, 75);
        quiet_in = ($urandom_range(0, 3) == 0);
        quiet_out = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 4)
        kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
      else if (pick < 12)
        kind = OP_ROTATE;
      else if (pick < 12 + push_pct * 88 / 100)
        kind = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else
        kind = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      send_item(kind, $urandom());
      if (kind < KIND_SPARE_FIRST) begin
        done++;
        seg_left--;
      end
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_value_extremes();
    test_half_rotate();
    test_full_queue();
    test_random_ops(RANDOM_ITEMS);
    if (mismatches == 0)
      $display("deque_with_half_rotate: match");
    else
      $display("deque_with_half_rotate: mismatch");
    $finish;
  end

endmodule

// ===== deque_with_half_rotate.f =====
+incdir+rtl
rtl/dqhr_pkg.sv
rtl/dqhr_ctrl.sv
rtl/dqhr_dp.sv
rtl/deque_with_half_rotate.sv
rtl/dqhr_checker.sv
bench/deque_with_half_rotate_tb.sv
